FILE: rtl/hrp_pkg.sv
`timescale 1ns / 1ps

package hrp_pkg;

  typedef enum logic [4:0] {
    ST_METHOD_START = 5'd0,
    ST_METHOD       = 5'd1,
    ST_URI_START    = 5'd2,
    ST_URI          = 5'd3,
    ST_H            = 5'd4,
    ST_T1           = 5'd5,
    ST_T2           = 5'd6,
    ST_P            = 5'd7,
    ST_SLASH        = 5'd8,
    ST_MAJ_START    = 5'd9,
    ST_MAJ          = 5'd10,
    ST_MIN_START    = 5'd11,
    ST_MIN          = 5'd12,
    ST_NL_LINE      = 5'd13,
    ST_LINE_START   = 5'd14,
    ST_LWS          = 5'd15,
    ST_NAME         = 5'd16,
    ST_SP_VALUE     = 5'd17,
    ST_VALUE        = 5'd18,
    ST_NL_HDR       = 5'd19,
    ST_NL_END       = 5'd20,
    ST_DONE         = 5'd21,
    ST_BAD          = 5'd22
  } parse_state_t;

  localparam logic [1:0] V_MORE = 2'd0;
  localparam logic [1:0] V_DONE = 2'd1;
  localparam logic [1:0] V_BAD  = 2'd2;

  localparam logic [2:0] C_NONE   = 3'd0;
  localparam logic [2:0] C_METHOD = 3'd1;
  localparam logic [2:0] C_URI    = 3'd2;
  localparam logic [2:0] C_NAME   = 3'd3;
  localparam logic [2:0] C_VALUE  = 3'd4;

  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CH_CTL_MAX = 8'd31;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [3:0] DEC_BASE = 4'd10;
  localparam logic [7:0] ACC_MAX  = 8'd255;

  // Parser context carried from one word to the next.
  typedef struct packed {
    parse_state_t state;
    logic [7:0]   major_acc;
    logic [7:0]   minor_acc;
    logic         header_seen;
  } parse_ctx_t;

  // Per-word classification produced by the step logic.
  typedef struct packed {
    logic [1:0] verdict;
    logic [2:0] byte_class;
    logic       header_start;
  } step_res_t;

  function automatic logic is_ctl(input logic [7:0] c);
    return (c <= CH_CTL_MAX) || (c == CH_DEL);
  endfunction

  function automatic logic is_special(input logic [7:0] c);
    logic r;
    case (c)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
      "/", "[", "]", "?", "=", "{", "}", CH_SP, CH_TAB: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_token(input logic [7:0] c);
    return !c[7] && !is_ctl(c) && !is_special(c);
  endfunction

  function automatic logic is_dec_char(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // acc * 10 + digit, clamped to 255.
  function automatic logic [7:0] sat_acc(input logic [7:0] acc, input logic [7:0] c);
    logic [11:0] v;
    v = {4'd0, acc} * {8'd0, DEC_BASE} + {8'd0, c[3:0]};
    return (v > {4'd0, ACC_MAX}) ? ACC_MAX : v[7:0];
  endfunction

endpackage

FILE: rtl/hrp_step.sv
`timescale 1ns / 1ps

module hrp_step (
  input  hrp_pkg::parse_ctx_t ctx,
  input  logic [7:0]          data,
  output hrp_pkg::parse_ctx_t ctx_nxt,
  output hrp_pkg::step_res_t  res
);
  import hrp_pkg::*;

  logic [2:0] cls;
  logic       hstart;

  always_comb begin
    ctx_nxt       = ctx;
    ctx_nxt.state = ST_BAD;
    cls           = C_NONE;
    hstart        = 1'b0;

    case (ctx.state)
      ST_METHOD_START: begin
        if (is_token(data)) begin
          ctx_nxt.state = ST_METHOD;
          cls = C_METHOD;
        end
      end
      ST_METHOD: begin
        if (data == CH_SP) begin
          ctx_nxt.state = ST_URI_START;
        end else if (is_token(data)) begin
          ctx_nxt.state = ST_METHOD;
          cls = C_METHOD;
        end
      end
      ST_URI_START: begin
        if (!is_ctl(data)) begin
          ctx_nxt.state = ST_URI;
          cls = C_URI;
        end
      end
      ST_URI: begin
        if (data == CH_SP) begin
          ctx_nxt.state = ST_H;
        end else if (!is_ctl(data)) begin
          ctx_nxt.state = ST_URI;
          cls = C_URI;
        end
      end
      ST_H: begin
        if (data == "H") ctx_nxt.state = ST_T1;
      end
      ST_T1: begin
        if (data == "T") ctx_nxt.state = ST_T2;
      end
      ST_T2: begin
        if (data == "T") ctx_nxt.state = ST_P;
      end
      ST_P: begin
        if (data == "P") ctx_nxt.state = ST_SLASH;
      end
      ST_SLASH: begin
        if (data == "/") begin
          ctx_nxt.major_acc = '0;
          ctx_nxt.minor_acc = '0;
          ctx_nxt.state = ST_MAJ_START;
        end
      end
      ST_MAJ_START: begin
        if (is_dec_char(data)) begin
          ctx_nxt.major_acc = sat_acc(ctx.major_acc, data);
          ctx_nxt.state = ST_MAJ;
        end
      end
      ST_MAJ: begin
        if (data == ".") begin
          ctx_nxt.state = ST_MIN_START;
        end else if (is_dec_char(data)) begin
          ctx_nxt.major_acc = sat_acc(ctx.major_acc, data);
          ctx_nxt.state = ST_MAJ;
        end
      end
      ST_MIN_START: begin
        if (is_dec_char(data)) begin
          ctx_nxt.minor_acc = sat_acc(ctx.minor_acc, data);
          ctx_nxt.state = ST_MIN;
        end
      end
      ST_MIN: begin
        if (data == CH_CR) begin
          ctx_nxt.state = ST_NL_LINE;
        end else if (is_dec_char(data)) begin
          ctx_nxt.minor_acc = sat_acc(ctx.minor_acc, data);
          ctx_nxt.state = ST_MIN;
        end
      end
      ST_NL_LINE: begin
        if (data == CH_LF) ctx_nxt.state = ST_LINE_START;
      end
      ST_LINE_START: begin
        // Leading whitespace only continues a value once a header exists.
        if (data == CH_CR) begin
          ctx_nxt.state = ST_NL_END;
        end else if (ctx.header_seen && (data == CH_SP || data == CH_TAB)) begin
          ctx_nxt.state = ST_LWS;
        end else if (is_token(data)) begin
          ctx_nxt.header_seen = 1'b1;
          ctx_nxt.state = ST_NAME;
          hstart = 1'b1;
          cls = C_NAME;
        end
      end
      ST_LWS: begin
        if (data == CH_CR) begin
          ctx_nxt.state = ST_NL_HDR;
        end else if (data == CH_SP || data == CH_TAB) begin
          ctx_nxt.state = ST_LWS;
        end else if (!is_ctl(data)) begin
          ctx_nxt.state = ST_VALUE;
          cls = C_VALUE;
        end
      end
      ST_NAME: begin
        if (data == ":") begin
          ctx_nxt.state = ST_SP_VALUE;
        end else if (is_token(data)) begin
          ctx_nxt.state = ST_NAME;
          cls = C_NAME;
        end
      end
      ST_SP_VALUE: begin
        if (data == CH_SP) ctx_nxt.state = ST_VALUE;
      end
      ST_VALUE: begin
        if (data == CH_CR) begin
          ctx_nxt.state = ST_NL_HDR;
        end else if (!is_ctl(data)) begin
          ctx_nxt.state = ST_VALUE;
          cls = C_VALUE;
        end
      end
      ST_NL_HDR: begin
        if (data == CH_LF) ctx_nxt.state = ST_LINE_START;
      end
      ST_NL_END: begin
        if (data == CH_LF) ctx_nxt.state = ST_DONE;
      end
      ST_DONE: begin
        ctx_nxt.state = ST_DONE;
      end
      default: begin
        ctx_nxt.state = ST_BAD;
      end
    endcase

    res.byte_class   = (ctx_nxt.state == ST_BAD) ? C_NONE : cls;
    res.header_start = (ctx_nxt.state == ST_BAD) ? 1'b0 : hstart;
    res.verdict      = (ctx_nxt.state == ST_DONE) ? V_DONE :
                       (ctx_nxt.state == ST_BAD)  ? V_BAD  : V_MORE;
  end

endmodule

FILE: rtl/http_request_head_parser_top.sv
`timescale 1ns / 1ps

// HTTP/1.0 request head parser. Each word on the input channel is one byte of
// the request stream; each produces exactly one result word carrying the
// verdict (more, complete, malformed), the byte's class, a header-start flag,
// the byte itself and the running major/minor version numbers. A byte is held
// in an input register, the parser state machine advances on it, and the
// result lands in an output register. Throughput is one byte per cycle while
// out_ready stays high; apart from output back-pressure, the limit is the state
// update feeding back into the parser context. Complete and malformed verdicts
// are sticky until reset.

module http_request_head_parser_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_verdict,
  output logic [2:0] out_byte_class,
  output logic       out_header_start,
  output logic [7:0] out_data_out,
  output logic [7:0] out_version_major,
  output logic [7:0] out_version_minor
);
  import hrp_pkg::*;

  logic       in_v_r;
  logic [7:0] in_data_r;
  logic       out_v_r;
  logic       advance;

  parse_ctx_t ctx_r;
  parse_ctx_t ctx_nxt;
  step_res_t  res;

  logic [1:0] verdict_r;
  logic [2:0] class_r;
  logic       hstart_r;
  logic [7:0] data_out_r;
  logic [7:0] major_r;
  logic [7:0] minor_r;

  // The held word moves to the output when the output slot is free or draining.
  assign advance  = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || advance;

  hrp_step u_step (
    .ctx     (ctx_r),
    .data    (in_data_r),
    .ctx_nxt (ctx_nxt),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r            <= 1'b0;
      out_v_r           <= 1'b0;
      ctx_r.state       <= ST_METHOD_START;
      ctx_r.major_acc   <= '0;
      ctx_r.minor_acc   <= '0;
      ctx_r.header_seen <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
        ctx_r   <= ctx_nxt;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      verdict_r  <= res.verdict;
      class_r    <= res.byte_class;
      hstart_r   <= res.header_start;
      data_out_r <= in_data_r;
      major_r    <= ctx_nxt.major_acc;
      minor_r    <= ctx_nxt.minor_acc;
    end
  end

  assign out_valid         = out_v_r;
  assign out_verdict       = verdict_r;
  assign out_byte_class    = class_r;
  assign out_header_start  = hstart_r;
  assign out_data_out      = data_out_r;
  assign out_version_major = major_r;
  assign out_version_minor = minor_r;

endmodule

FILE: dv/tb_http_request_head_parser_top.sv
`timescale 1ns / 1ps

module tb_http_request_head_parser_top;
  import hrp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HEAD_BYTES  = 1050;
  localparam int TAIL_BYTES  = 20;
  // Separators that fall inside the printable range; space and tab are below it.
  localparam logic [8*17-1:0] SEP_CHARS = "()<>@,;:\\\"/[]?={}";

  typedef struct packed {
    logic [1:0] verdict;
    logic [2:0] byte_class;
    logic       header_start;
    logic [7:0] data;
    logic [7:0] major;
    logic [7:0] minor;
  } head_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_verdict;
  logic [2:0] out_byte_class;
  logic       out_header_start;
  logic [7:0] out_data_out;
  logic [7:0] out_version_major;
  logic [7:0] out_version_minor;

  logic [7:0] byte_stream[$];
  int         head_len;
  int         header_count;
  int         fold_count;
  string      end_kind;

  function automatic bit ctl_char(logic [7:0] c);
    return (c < 8'd32) || (c == CH_DEL);
  endfunction

  function automatic bit tok_char(logic [7:0] c);
    if (c < 8'd33 || c > 8'd126) return 1'b0;
    for (int i = 0; i < 17; i++) begin
      if (SEP_CHARS[8*i +: 8] == c) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] add_digit(logic [7:0] acc, logic [7:0] c);
    int v;
    v = int'(acc) * 10 + int'(c) - int'(CH_ZERO);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  class head_verdict_board;
    parse_state_t st;
    logic [7:0]   major_acc;
    logic [7:0]   minor_acc;
    bit           header_seen;
    head_word_t   pending[$];
    int           words_checked;
    int           errors;

    function new();
      st = ST_METHOD_START;
      major_acc = 8'd0;
      minor_acc = 8'd0;
      header_seen = 1'b0;
      words_checked = 0;
      errors = 0;
    endfunction

    // Advances the parser by one accepted byte and queues the word it should produce.
    function void take_byte(logic [7:0] c);
      parse_state_t nxt;
      logic [2:0]   cls;
      bit           hs;
      bit           dig;
      head_word_t   w;
      nxt = ST_BAD;
      cls = C_NONE;
      hs = 1'b0;
      dig = (c >= CH_ZERO) && (c <= CH_NINE);
      case (st)
        ST_METHOD_START: if (tok_char(c)) begin
          nxt = ST_METHOD;
          cls = C_METHOD;
        end
        ST_METHOD: if (c == CH_SP) begin
          nxt = ST_URI_START;
        end else if (tok_char(c)) begin
          nxt = ST_METHOD;
          cls = C_METHOD;
        end
        ST_URI_START: if (!ctl_char(c)) begin
          nxt = ST_URI;
          cls = C_URI;
        end
        ST_URI: if (c == CH_SP) begin
          nxt = ST_H;
        end else if (!ctl_char(c)) begin
          nxt = ST_URI;
          cls = C_URI;
        end
        ST_H: if (c == "H") nxt = ST_T1;
        ST_T1: if (c == "T") nxt = ST_T2;
        ST_T2: if (c == "T") nxt = ST_P;
        ST_P: if (c == "P") nxt = ST_SLASH;
        ST_SLASH: if (c == "/") begin
          major_acc = 8'd0;
          minor_acc = 8'd0;
          nxt = ST_MAJ_START;
        end
        ST_MAJ_START: if (dig) begin
          major_acc = add_digit(major_acc, c);
          nxt = ST_MAJ;
        end
        ST_MAJ: if (c == ".") begin
          nxt = ST_MIN_START;
        end else if (dig) begin
          major_acc = add_digit(major_acc, c);
          nxt = ST_MAJ;
        end
        ST_MIN_START: if (dig) begin
          minor_acc = add_digit(minor_acc, c);
          nxt = ST_MIN;
        end
        ST_MIN: if (c == CH_CR) begin
          nxt = ST_NL_LINE;
        end else if (dig) begin
          minor_acc = add_digit(minor_acc, c);
          nxt = ST_MIN;
        end
        ST_NL_LINE: if (c == CH_LF) nxt = ST_LINE_START;
        ST_LINE_START: if (c == CH_CR) begin
          nxt = ST_NL_END;
        end else if (header_seen && (c == CH_SP || c == CH_TAB)) begin
          nxt = ST_LWS;
        end else if (tok_char(c)) begin
          header_seen = 1'b1;
          hs = 1'b1;
          cls = C_NAME;
          nxt = ST_NAME;
        end
        ST_LWS: if (c == CH_CR) begin
          nxt = ST_NL_HDR;
        end else if (c == CH_SP || c == CH_TAB) begin
          nxt = ST_LWS;
        end else if (!ctl_char(c)) begin
          nxt = ST_VALUE;
          cls = C_VALUE;
        end
        ST_NAME: if (c == ":") begin
          nxt = ST_SP_VALUE;
        end else if (tok_char(c)) begin
          nxt = ST_NAME;
          cls = C_NAME;
        end
        ST_SP_VALUE: if (c == CH_SP) nxt = ST_VALUE;
        ST_VALUE: if (c == CH_CR) begin
          nxt = ST_NL_HDR;
        end else if (!ctl_char(c)) begin
          nxt = ST_VALUE;
          cls = C_VALUE;
        end
        ST_NL_HDR: if (c == CH_LF) nxt = ST_LINE_START;
        ST_NL_END: if (c == CH_LF) nxt = ST_DONE;
        ST_DONE: nxt = ST_DONE;
        default: nxt = ST_BAD;
      endcase
      st = nxt;
      w.verdict = (nxt == ST_DONE) ? V_DONE : (nxt == ST_BAD) ? V_BAD : V_MORE;
      w.byte_class = cls;
      w.header_start = hs;
      w.data = c;
      w.major = major_acc;
      w.minor = minor_acc;
      pending.insert(pending.size(), w);
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch on word %0d: expected %0d, got %0d",
                 $time, field, words_checked, want, got);
      end
    endfunction

    function void check_word(head_word_t got);
      head_word_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: expected none, got data %0d verdict %0d",
                 $time, got.data, got.verdict);
        return;
      end
      want = pending.pop_front();
      compare_field("verdict", 8'(want.verdict), 8'(got.verdict));
      compare_field("byte_class", 8'(want.byte_class), 8'(got.byte_class));
      compare_field("header_start", 8'(want.header_start), 8'(got.header_start));
      compare_field("data_out", want.data, got.data);
      compare_field("version_major", want.major, got.major);
      compare_field("version_minor", want.minor, got.minor);
      words_checked++;
    endfunction
  endclass

  head_verdict_board board;

  http_request_head_parser_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data           (in_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_verdict       (out_verdict),
    .out_byte_class    (out_byte_class),
    .out_header_start  (out_header_start),
    .out_data_out      (out_data_out),
    .out_version_major (out_version_major),
    .out_version_minor (out_version_minor)
  );

  always #5 clk = ~clk;

  function automatic void append_byte(logic [7:0] b);
    byte_stream.insert(byte_stream.size(), b);
  endfunction

  function automatic logic [7:0] pick_token_char();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126)); while (!tok_char(c));
    return c;
  endfunction

  function automatic logic [7:0] pick_text_char(bit allow_space);
    logic [7:0] c;
    do c = 8'($urandom_range(allow_space ? 32 : 33, 255)); while (c == CH_DEL);
    return c;
  endfunction

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endtask

  task automatic build_stream();
    logic [7:0] c;
    int         n;
    // Request line: extreme method characters, a space taken as the first URI
    // character, non-ASCII in the URI and a major version that saturates.
    push_text("!~  ");
    append_byte(8'hff);
    append_byte(8'h80);
    push_text("~ HTTP/999.0");
    append_byte(CH_CR);
    append_byte(CH_LF);
    header_count = 0;
    fold_count = 0;
    while (byte_stream.size() < HEAD_BYTES) begin
      if (header_count > 0 && $urandom_range(0, 3) == 0) begin
        // Folded continuation of the previous value, sometimes empty.
        fold_count++;
        n = $urandom_range(1, 3);
        repeat (n) append_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
        if ($urandom_range(0, 1)) begin
          n = $urandom_range(1, 15);
          repeat (n) append_byte(pick_text_char(1'b1));
        end
      end else begin
        header_count++;
        n = $urandom_range(1, 12);
        repeat (n) append_byte(pick_token_char());
        push_text(": ");
        n = $urandom_range(0, 24);
        repeat (n) append_byte(pick_text_char(1'b1));
      end
      append_byte(CH_CR);
      append_byte(CH_LF);
    end
    case ($urandom_range(0, 3))
      2: begin
        end_kind = "malformed after a lone CR";
        do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
        append_byte(CH_CR);
        append_byte(c);
      end
      3: begin
        end_kind = "malformed at a line start";
        do c = 8'($urandom_range(0, 255));
        while (tok_char(c) || c == CH_CR || c == CH_SP || c == CH_TAB);
        append_byte(c);
      end
      default: begin
        end_kind = "complete";
        append_byte(CH_CR);
        append_byte(CH_LF);
      end
    endcase
    head_len = byte_stream.size();
    // The verdict is sticky from here on; any byte value may follow.
    repeat (TAIL_BYTES) append_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic drive_bytes();
    int burst_left;
    int gap;
    burst_left = $urandom_range(1, 40);
    foreach (byte_stream[i]) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        gap = $urandom_range(1, 8);
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 40);
      end
      in_valid <= 1'b1;
      in_data <= byte_stream[i];
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      burst_left--;
    end
    in_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    head_word_t got;
    if (rst_n) begin
      if (in_valid && in_ready) board.take_byte(in_data);
      if (out_valid && out_ready) begin
        got.verdict = out_verdict;
        got.byte_class = out_byte_class;
        got.header_start = out_header_start;
        got.data = out_data_out;
        got.major = out_version_major;
        got.minor = out_version_minor;
        board.check_word(got);
      end
    end
  end

  // Receiver: random stall patterns of varying ready ratio, plus one long
  // hold-off so the parser backs up and drops in_ready.
  initial begin : result_sink
    int  mode_left;
    int  ready_pct;
    bit  held;
    mode_left = 0;
    ready_pct = 100;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && rst_n && board.words_checked >= 400) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 80);
        case ($urandom_range(0, 3))
          0: ready_pct = 100;
          1: ready_pct = 75;
          2: ready_pct = 50;
          default: ready_pct = 20;
        endcase
      end
      mode_left--;
      out_ready <= ($urandom_range(1, 100) <= ready_pct);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles with %0d words outstanding",
             CYCLE_LIMIT, board.pending.size());
    $display("Verification failed");
    $finish;
  end

  initial begin : main_seq
    board = new();
    build_stream();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    drive_bytes();
    // Wait so the last accepted byte is already on the board.
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent a %0d-byte request head (%0d headers, %0d folded lines), %s,",
             head_len, header_count, fold_count, end_kind);
    $display("then %0d more bytes; checked %0d result words, %0d field mismatches.",
             TAIL_BYTES, board.words_checked, board.errors);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: http_request_head_parser_top.f
rtl/hrp_pkg.sv
rtl/hrp_step.sv
rtl/http_request_head_parser_top.sv
dv/tb_http_request_head_parser_top.sv
